// ----- hdl/htc_pkg.sv -----
`default_nettype none

package htc_pkg;

    localparam int DEF_ALPHABET_SIZE = 256;
    localparam int DEF_COUNT_BITS    = 20;
    localparam int DEF_MAX_CODE_LEN  = 48;

    localparam logic [1:0] OP_COUNT  = 2'd0;
    localparam logic [1:0] OP_BUILD  = 2'd1;
    localparam logic [1:0] OP_ENCODE = 2'd2;
    localparam logic [1:0] OP_DECODE = 2'd3;

    localparam logic [1:0] KIND_BUILD = 2'd0;
    localparam logic [1:0] KIND_CODE  = 2'd1;
    localparam logic [1:0] KIND_SYM   = 2'd2;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_NO_TREE  = 3'd1;
    localparam logic [2:0] ERR_DEEP     = 3'd2;
    localparam logic [2:0] ERR_NO_CODE  = 3'd3;
    localparam logic [2:0] ERR_BAD_PATH = 3'd4;

    typedef struct packed {
        logic rd;
        logic inc;
        logic clr;
    } t_hist_cmd;

endpackage

`default_nettype wire

// ----- hdl/htc_ram.sv -----
`default_nettype none

module htc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/htc_hist.sv -----
`default_nettype none

module htc_hist #(
    parameter int ALPHABET_SIZE = htc_pkg::DEF_ALPHABET_SIZE,
    parameter int COUNT_BITS    = htc_pkg::DEF_COUNT_BITS,
    localparam int SW = $clog2(ALPHABET_SIZE)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire htc_pkg::t_hist_cmd    i_cmd,
    input  wire logic [SW-1:0]         i_addr,
    output logic      [COUNT_BITS-1:0] o_rdata
);

    logic [ALPHABET_SIZE-1:0] r_vld;
    logic [SW-1:0]            r_addr;
    logic                     r_vq;
    logic [COUNT_BITS-1:0]    ram_q;
    logic [COUNT_BITS-1:0]    inc_val;

    // An entry whose valid bit is clear reads as zero, so reset and the
    // clear after a build need no pass through the memory.
    assign o_rdata = r_vq ? ram_q : '0;
    assign inc_val = (&o_rdata) ? o_rdata : o_rdata + 1'b1;

    htc_ram #(.WIDTH(COUNT_BITS), .DEPTH(ALPHABET_SIZE)) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.inc),
        .i_wr_addr(r_addr),
        .i_wr_data(inc_val),
        .i_rd_en  (i_cmd.rd),
        .i_rd_addr(i_addr),
        .o_rd_data(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.clr) begin
            r_vld <= '0;
        end else if (i_cmd.inc) begin
            r_vld[r_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_addr <= i_addr;
            r_vq   <= r_vld[i_addr] && !i_cmd.clr;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/htc_min2.sv -----
`default_nettype none

module htc_min2 #(
    parameter int NW = 9,
    parameter int WW = 28
) (
    input  wire logic          i_clk,
    input  wire logic          i_start,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_idx,
    input  wire logic          i_live,
    input  wire logic [WW-1:0] i_weight,
    output logic      [NW-1:0] o_best_idx,
    output logic      [WW-1:0] o_best_w,
    output logic      [NW-1:0] o_sec_idx,
    output logic      [WW-1:0] o_sec_w
);

    logic r_bf;
    logic r_sf;

    // Nodes arrive in ascending index order; a strict compare keeps the
    // lower index on equal weights.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bf <= 1'b0;
            r_sf <= 1'b0;
        end else if (i_valid && i_live) begin
            if (!r_bf || i_weight < o_best_w) begin
                o_sec_idx  <= o_best_idx;
                o_sec_w    <= o_best_w;
                r_sf       <= r_bf;
                o_best_idx <= i_idx;
                o_best_w   <= i_weight;
                r_bf       <= 1'b1;
            end else if (!r_sf || i_weight < o_sec_w) begin
                o_sec_idx <= i_idx;
                o_sec_w   <= i_weight;
                r_sf      <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/huffman_table_codec.sv -----
// Channel  Handshake          Direction  Beat
// input    i_valid/o_ready    in         i_op, i_symbol, i_code_bit
// output   o_valid/i_ready    out        o_result_kind .. o_error
//
// Build reads every histogram entry into a leaf node, then runs one merge per
// inner node: each merge scans the node memory one entry a cycle for the two
// lightest. Code assignment then walks the inner nodes downwards.
// One item is in work at a time; a result waits in the output register
// while the next beat is taken. Reset is synchronous; no clearing pass.
`default_nettype none

module huffman_table_codec #(
    parameter int ALPHABET_SIZE = htc_pkg::DEF_ALPHABET_SIZE,
    parameter int COUNT_BITS    = htc_pkg::DEF_COUNT_BITS,
    parameter int MAX_CODE_LEN  = htc_pkg::DEF_MAX_CODE_LEN
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_symbol,
    input  wire logic        i_code_bit,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_out_symbol,
    output logic [47:0]      o_code_value,
    output logic [5:0]       o_code_length,
    output logic [8:0]       o_distinct_symbols,
    output logic [2:0]       o_error
);

    localparam int NODES  = 2 * ALPHABET_SIZE - 1;
    localparam int INNERS = ALPHABET_SIZE - 1;
    localparam int SW  = $clog2(ALPHABET_SIZE);
    localparam int NW  = $clog2(NODES);
    localparam int LKW = (INNERS > 1) ? $clog2(INNERS) : 1;
    localparam int CW  = $clog2(ALPHABET_SIZE + 1);
    localparam int WW  = COUNT_BITS + SW;
    localparam int ML  = MAX_CODE_LEN;
    localparam int LW  = $clog2(MAX_CODE_LEN + 1);
    localparam logic [NW-1:0] A_N = NW'(ALPHABET_SIZE);
    localparam logic [SW-1:0] LAST_SYM = SW'(ALPHABET_SIZE - 1);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_CNT      = 5'd1;
    localparam logic [4:0] S_ENC      = 5'd2;
    localparam logic [4:0] S_DEC      = 5'd3;
    localparam logic [4:0] S_INIT     = 5'd4;
    localparam logic [4:0] S_INIT_END = 5'd5;
    localparam logic [4:0] S_BDEC     = 5'd6;
    localparam logic [4:0] S_SCAN     = 5'd7;
    localparam logic [4:0] S_MRG_A    = 5'd8;
    localparam logic [4:0] S_MRG_B    = 5'd9;
    localparam logic [4:0] S_MRG_N    = 5'd10;
    localparam logic [4:0] S_CP_ROOT  = 5'd11;
    localparam logic [4:0] S_CP_RD    = 5'd12;
    localparam logic [4:0] S_CP_C0    = 5'd13;
    localparam logic [4:0] S_CP_C1    = 5'd14;
    localparam logic [4:0] S_FIN      = 5'd15;
    localparam logic [4:0] S_EMIT     = 5'd16;

    logic [4:0]    r_state, n_state;
    logic          r_ready, n_ready;
    logic [NW-1:0] r_root, n_root;
    logic [NW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_n, n_n;
    logic          r_bsc, n_bsc;
    logic [SW-1:0] r_lone, n_lone;
    logic [SW-1:0] r_s, n_s;
    logic [NW-1:0] r_next, n_next;
    logic [CW-1:0] r_m, n_m;
    logic [NW-1:0] r_idx, n_idx;
    logic [LKW-1:0] r_k, n_k;
    logic          r_deep, n_deep;
    logic          r_bit, n_bit;
    logic          r_cnt_ok, n_cnt_ok;
    logic          r_ipend;
    logic [SW-1:0] r_iidx;
    logic          r_spend;
    logic [NW-1:0] r_sidx;

    logic [1:0]    r_rk, n_rk;
    logic [7:0]    r_rsym, n_rsym;
    logic [ML-1:0] r_rval, n_rval;
    logic [LW-1:0] r_rlen, n_rlen;
    logic [CW-1:0] r_rdist, n_rdist;
    logic [2:0]    r_rerr, n_rerr;
    logic          r_ov;
    logic          emit_load;

    logic          in_acc;
    logic          sym_ok;
    logic [NW-1:0] cur_eff;

    htc_pkg::t_hist_cmd h_cmd;
    logic [SW-1:0]         h_addr;
    logic [COUNT_BITS-1:0] h_q;

    logic          nd_we, nd_re;
    logic [NW-1:0] nd_wa, nd_ra;
    logic [WW:0]   nd_wd, nd_q;
    logic          lk_we, pf_we, lk_re;
    logic [LKW-1:0] lk_wa, pf_wa, lk_ra;
    logic [2*NW-1:0] lk_wd, lk_q;
    logic [ML+CW-1:0] pf_wd, pf_q;
    logic          cd_we, cd_re;
    logic [SW-1:0] cd_wa, cd_ra;
    logic [ML+LW-1:0] cd_wd, cd_q;

    logic          min_start;
    logic [NW-1:0] best_i, sec_i;
    logic [WW-1:0] best_w, sec_w;

    logic          cp_c;
    logic [NW-1:0] cp_ch;
    logic [ML-1:0] cp_v;
    logic [CW-1:0] cp_l;
    logic [NW-1:0] dec_ch;

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign sym_ok  = ({1'b0, i_symbol} < 9'(ALPHABET_SIZE));
    assign cur_eff = (r_cur < A_N) ? r_root : r_cur;
    assign o_valid = r_ov;

    assign cp_c   = (r_state == S_CP_C1);
    assign cp_ch  = cp_c ? lk_q[2*NW-1:NW] : lk_q[NW-1:0];
    assign cp_v   = {pf_q[ML+CW-2:CW], cp_c};
    assign cp_l   = pf_q[CW-1:0] + 1'b1;
    assign dec_ch = r_bit ? lk_q[2*NW-1:NW] : lk_q[NW-1:0];

    htc_hist #(.ALPHABET_SIZE(ALPHABET_SIZE), .COUNT_BITS(COUNT_BITS)) u_hist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (h_cmd),
        .i_addr (h_addr),
        .o_rdata(h_q)
    );

    htc_ram #(.WIDTH(WW + 1), .DEPTH(NODES)) u_node (
        .i_clk(i_clk), .i_wr_en(nd_we), .i_wr_addr(nd_wa), .i_wr_data(nd_wd),
        .i_rd_en(nd_re), .i_rd_addr(nd_ra), .o_rd_data(nd_q)
    );

    htc_ram #(.WIDTH(2 * NW), .DEPTH(INNERS)) u_link (
        .i_clk(i_clk), .i_wr_en(lk_we), .i_wr_addr(lk_wa), .i_wr_data(lk_wd),
        .i_rd_en(lk_re), .i_rd_addr(lk_ra), .o_rd_data(lk_q)
    );

    htc_ram #(.WIDTH(ML + CW), .DEPTH(INNERS)) u_prefix (
        .i_clk(i_clk), .i_wr_en(pf_we), .i_wr_addr(pf_wa), .i_wr_data(pf_wd),
        .i_rd_en(lk_re), .i_rd_addr(lk_ra), .o_rd_data(pf_q)
    );

    htc_ram #(.WIDTH(ML + LW), .DEPTH(ALPHABET_SIZE)) u_code (
        .i_clk(i_clk), .i_wr_en(cd_we), .i_wr_addr(cd_wa), .i_wr_data(cd_wd),
        .i_rd_en(cd_re), .i_rd_addr(cd_ra), .o_rd_data(cd_q)
    );

    htc_min2 #(.NW(NW), .WW(WW)) u_min2 (
        .i_clk     (i_clk),
        .i_start   (min_start),
        .i_valid   (r_spend),
        .i_idx     (r_sidx),
        .i_live    (nd_q[WW]),
        .i_weight  (nd_q[WW-1:0]),
        .o_best_idx(best_i),
        .o_best_w  (best_w),
        .o_sec_idx (sec_i),
        .o_sec_w   (sec_w)
    );

    always_comb begin
        n_state = r_state;  n_ready = r_ready;  n_root = r_root;  n_cur = r_cur;
        n_n = r_n;  n_bsc = r_bsc;  n_lone = r_lone;  n_s = r_s;  n_next = r_next;
        n_m = r_m;  n_idx = r_idx;  n_k = r_k;  n_deep = r_deep;  n_bit = r_bit;
        n_cnt_ok = r_cnt_ok;
        n_rk = r_rk;  n_rsym = r_rsym;  n_rval = r_rval;  n_rlen = r_rlen;
        n_rdist = r_rdist;  n_rerr = r_rerr;
        h_cmd = '0;  h_addr = i_symbol[SW-1:0];
        nd_we = 1'b0;  nd_wa = '0;  nd_wd = '0;  nd_re = 1'b0;  nd_ra = r_idx;
        lk_we = 1'b0;  lk_wa = '0;  lk_wd = '0;  lk_re = 1'b0;  lk_ra = r_k;
        pf_we = 1'b0;  pf_wa = '0;  pf_wd = '0;
        cd_we = 1'b0;  cd_wa = '0;  cd_wd = '0;  cd_re = 1'b0;
        cd_ra = i_symbol[SW-1:0];
        min_start = 1'b0;
        emit_load = 1'b0;

        // Histogram entries drain into the leaf nodes in the cycle after the read.
        if (r_ipend) begin
            nd_we = 1'b1;
            nd_wa = NW'(r_iidx);
            nd_wd = {(h_q != '0), WW'(h_q)};
            cd_we = 1'b1;
            cd_wa = r_iidx;
            if (h_q != '0) begin
                n_n    = r_n + 1'b1;
                n_lone = r_iidx;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_rval  = '0;
                    n_rlen  = '0;
                    n_rdist = '0;
                    n_rsym  = 8'd0;
                    case (i_op)
                        htc_pkg::OP_COUNT: begin
                            h_cmd.rd = 1'b1;
                            if (r_bsc) begin
                                h_cmd.clr = 1'b1;
                                n_bsc     = 1'b0;
                            end
                            n_cnt_ok = sym_ok;
                            n_state  = S_CNT;
                        end
                        htc_pkg::OP_BUILD: begin
                            n_bsc   = 1'b1;
                            n_ready = 1'b0;
                            n_root  = '0;
                            n_cur   = '0;
                            n_n     = '0;
                            n_s     = '0;
                            n_state = S_INIT;
                        end
                        htc_pkg::OP_ENCODE: begin
                            n_rk   = htc_pkg::KIND_CODE;
                            n_rsym = i_symbol;
                            if (!r_ready) begin
                                n_rerr  = htc_pkg::ERR_NO_TREE;
                                n_state = S_EMIT;
                            end else if (!sym_ok) begin
                                n_rerr  = htc_pkg::ERR_NO_CODE;
                                n_state = S_EMIT;
                            end else begin
                                cd_re   = 1'b1;
                                n_state = S_ENC;
                            end
                        end
                        default: begin
                            n_rk = htc_pkg::KIND_SYM;
                            if (!r_ready) begin
                                n_rerr  = htc_pkg::ERR_NO_TREE;
                                n_state = S_EMIT;
                            end else if (r_root < A_N) begin
                                // A tree of one leaf: only a zero bit is a path.
                                n_cur = r_root;
                                if (!i_code_bit) begin
                                    n_rsym = 8'(r_root);
                                    n_rerr = htc_pkg::ERR_OK;
                                end else begin
                                    n_rerr = htc_pkg::ERR_BAD_PATH;
                                end
                                n_state = S_EMIT;
                            end else begin
                                lk_re   = 1'b1;
                                lk_ra   = LKW'(cur_eff - A_N);
                                n_cur   = cur_eff;
                                n_bit   = i_code_bit;
                                n_state = S_DEC;
                            end
                        end
                    endcase
                end
            end
            S_CNT: begin
                h_cmd.inc = r_cnt_ok;
                n_state   = S_IDLE;
            end
            S_ENC: begin
                if (cd_q[LW-1:0] == '0) begin
                    n_rerr = htc_pkg::ERR_NO_CODE;
                end else begin
                    n_rval = cd_q[ML+LW-1:LW];
                    n_rlen = cd_q[LW-1:0];
                    n_rerr = htc_pkg::ERR_OK;
                end
                n_state = S_EMIT;
            end
            S_DEC: begin
                if (dec_ch < A_N) begin
                    n_rsym  = 8'(dec_ch);
                    n_rerr  = htc_pkg::ERR_OK;
                    n_cur   = r_root;
                    n_state = S_EMIT;
                end else begin
                    n_cur   = dec_ch;
                    n_state = S_IDLE;
                end
            end
            S_INIT: begin
                h_cmd.rd = 1'b1;
                h_addr   = r_s;
                if (r_s == LAST_SYM) begin
                    n_state = S_INIT_END;
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            S_INIT_END: begin
                n_state = S_BDEC;
            end
            S_BDEC: begin
                n_rk    = htc_pkg::KIND_BUILD;
                n_rdist = r_n;
                if (r_n == '0) begin
                    n_rerr  = htc_pkg::ERR_NO_TREE;
                    n_state = S_EMIT;
                end else if (r_n == CW'(1)) begin
                    cd_we   = 1'b1;
                    cd_wa   = r_lone;
                    cd_wd   = {ML'(0), LW'(1)};
                    n_root  = NW'(r_lone);
                    n_cur   = NW'(r_lone);
                    n_ready = 1'b1;
                    n_rerr  = htc_pkg::ERR_OK;
                    n_state = S_EMIT;
                end else begin
                    n_next    = A_N;
                    n_m       = r_n - 1'b1;
                    n_idx     = '0;
                    min_start = 1'b1;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx != r_next) begin
                    nd_re = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else if (!r_spend) begin
                    n_state = S_MRG_A;
                end
            end
            S_MRG_A: begin
                nd_we   = 1'b1;
                nd_wa   = best_i;
                nd_wd   = {1'b0, best_w};
                n_state = S_MRG_B;
            end
            S_MRG_B: begin
                nd_we   = 1'b1;
                nd_wa   = sec_i;
                nd_wd   = {1'b0, sec_w};
                n_state = S_MRG_N;
            end
            S_MRG_N: begin
                nd_we  = 1'b1;
                nd_wa  = r_next;
                nd_wd  = {1'b1, best_w + sec_w};
                lk_we  = 1'b1;
                lk_wa  = LKW'(r_next - A_N);
                lk_wd  = {sec_i, best_i};
                n_next = r_next + 1'b1;
                n_m    = r_m - 1'b1;
                if (r_m == CW'(1)) begin
                    n_state = S_CP_ROOT;
                end else begin
                    n_idx     = '0;
                    min_start = 1'b1;
                    n_state   = S_SCAN;
                end
            end
            S_CP_ROOT: begin
                n_root  = r_next - 1'b1;
                pf_we   = 1'b1;
                pf_wa   = LKW'(r_next - 1'b1 - A_N);
                n_k     = LKW'(r_next - 1'b1 - A_N);
                n_deep  = 1'b0;
                n_state = S_CP_RD;
            end
            S_CP_RD: begin
                lk_re   = 1'b1;
                n_state = S_CP_C0;
            end
            S_CP_C0, S_CP_C1: begin
                // Children always precede their parent, so walking the inner
                // nodes downwards sees every prefix before it is used.
                if (cp_ch >= A_N) begin
                    pf_we = 1'b1;
                    pf_wa = LKW'(cp_ch - A_N);
                    pf_wd = {cp_v, cp_l};
                end else if (int'(cp_l) > MAX_CODE_LEN) begin
                    n_deep = 1'b1;
                end else begin
                    cd_we = 1'b1;
                    cd_wa = SW'(cp_ch);
                    cd_wd = {cp_v, LW'(cp_l)};
                end
                if (!cp_c) begin
                    n_state = S_CP_C1;
                end else if (r_k == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = S_CP_RD;
                end
            end
            S_FIN: begin
                n_rk    = htc_pkg::KIND_BUILD;
                n_rdist = r_n;
                if (r_deep) begin
                    n_rerr = htc_pkg::ERR_DEEP;
                end else begin
                    n_ready = 1'b1;
                    n_cur   = r_root;
                    n_rerr  = htc_pkg::ERR_OK;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ov || i_ready) begin
                    emit_load = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
            r_root  <= '0;
            r_cur   <= '0;
            r_n     <= '0;
            r_bsc   <= 1'b0;
            r_ipend <= 1'b0;
            r_spend <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_root  <= n_root;
            r_cur   <= n_cur;
            r_n     <= n_n;
            r_bsc   <= n_bsc;
            r_ipend <= (r_state == S_INIT);
            r_spend <= (r_state == S_SCAN) && (r_idx != r_next);
            r_ov    <= emit_load || (r_ov && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_lone   <= n_lone;
        r_s      <= n_s;
        r_next   <= n_next;
        r_m      <= n_m;
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_deep   <= n_deep;
        r_bit    <= n_bit;
        r_cnt_ok <= n_cnt_ok;
        r_iidx   <= r_s;
        r_sidx   <= r_idx;
        r_rk     <= n_rk;
        r_rsym   <= n_rsym;
        r_rval   <= n_rval;
        r_rlen   <= n_rlen;
        r_rdist  <= n_rdist;
        r_rerr   <= n_rerr;
        if (emit_load) begin
            o_result_kind      <= r_rk;
            o_out_symbol       <= r_rsym;
            o_code_value       <= 48'(r_rval);
            o_code_length      <= 6'(r_rlen);
            o_distinct_symbols <= 9'(r_rdist);
            o_error            <= r_rerr;
        end
    end

`ifndef NO_ASSERTIONS
    a_decode_no_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_op == htc_pkg::OP_DECODE && !r_ready |=> r_state == S_EMIT)
        else $error("decode without a tree did not answer at once");

    a_root_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready && r_n > CW'(1) |-> r_root >= A_N)
        else $error("tree of several symbols has a leaf as root");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(ALPHABET_SIZE))
        else $error("symbol total beyond alphabet");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_next < NW'(NODES) && r_m != '0)
        else $error("merge scan beyond node store");
`endif

endmodule

`default_nettype wire
